// ===== rtl/rdat_pkg.sv =====
// Shared constants and codes for the RTC drift auto-trim block.
package rdat_pkg;

  // Register reset values.
  localparam logic [28:0] REF_CLOCK_RESET    = 29'd168000000;
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd600000;

  // Default subsecond span of the RTC.
  localparam int SUBS_SPAN_DEF = 32768;

  // One trim code step is worth STEP_NUM / STEP_DEN ppm, with a negative sign.
  localparam int STEP_NUM  = 4871;
  localparam int STEP_DEN  = 5110;
  localparam int PPM_SCALE = 1000000;
  localparam int MS_SCALE  = 1000;

  // Datapath widths of the shared divider.
  localparam int TICK_W = 64;
  localparam int MS_W   = 10;
  localparam int NUM_W  = TICK_W + MS_W;
  localparam int Q_W    = 32;
  localparam int HI_W   = NUM_W - Q_W;
  localparam int DVS_W  = 33;

  // Saturation limits.
  localparam logic signed [9:0]  CODE_MAX  = 10'sh1FF;
  localparam logic signed [9:0]  CODE_MIN  = 10'sh200;
  localparam logic signed [15:0] DRIFT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DRIFT_MIN = 16'sh8000;

  // Result action codes.
  localparam logic [1:0] ACT_WAIT  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_TRIM  = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] CFG_REF_CLOCK    = 1'b0;
  localparam logic [0:0] CFG_MIN_INTERVAL = 1'b1;

endpackage

// ===== rtl/rtc_drift_auto_trim_core.sv =====
// RTC drift auto-trim core: sequencer around one shared 32-step restoring divider.
// A stamp reset runs only the trim ppm division, an item that waits for the interval
// also runs the reference ms division, and a trim update runs all five divisions.
// Every division (trim ppm, reference ms, RTC ms, drift, new code) runs 32 steps
// on the same divider; one item is in work at a time, and the next item is accepted
// the cycle after the result is loaded into the output register.
// Synchronous active-low reset restores register defaults and clears stamps and trim.
module rtc_drift_auto_trim_core #(
  parameter int SUBS_SPAN = rdat_pkg::SUBS_SPAN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_rtc_seconds,
  input  logic [14:0]        in_rtc_subs,
  input  logic [63:0]        in_ref_ticks,
  input  logic               in_reset_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_action,
  output logic signed [9:0]  out_cal_code,
  output logic signed [9:0]  out_cal_ppm,
  output logic [31:0]        out_ref_elapsed_ms,
  output logic [31:0]        out_rtc_elapsed_ms,
  output logic signed [15:0] out_drift_ppm,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SPW   = $clog2(SUBS_SPAN + 1);
  localparam int D_W   = 32 + SPW;
  localparam int S_W   = D_W + 1;
  localparam int RN_W  = D_W + rdat_pkg::MS_W;
  localparam int NUM_W = rdat_pkg::NUM_W;
  localparam int HI_W  = rdat_pkg::HI_W;
  localparam int Q_W   = rdat_pkg::Q_W;
  localparam int DVS_W = rdat_pkg::DVS_W;
  localparam int CNT_W = $clog2(Q_W);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_LOAD     = 17'h00002,
    S_DIV      = 17'h00004,
    S_PPM_END  = 17'h00008,
    S_DT       = 17'h00010,
    S_REF_PREP = 17'h00020,
    S_REF_END  = 17'h00040,
    S_SUB      = 17'h00080,
    S_RTC_PREP = 17'h00100,
    S_RTC_END  = 17'h00200,
    S_DISP     = 17'h00400,
    S_DR_PREP  = 17'h00800,
    S_DR_END   = 17'h01000,
    S_CODE     = 17'h02000,
    S_CD_PREP  = 17'h04000,
    S_CD_END   = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  state_t state_r, state_nxt, ret_r;

  // Configuration and saved measurement state.
  logic [28:0]        hz_r;
  logic [31:0]        min_ms_r;
  logic [31:0]        sv_sec_r;
  logic [14:0]        sv_subs_r;
  logic [63:0]        sv_ticks_r;
  logic signed [9:0]  trim_code_r;

  // Captured item.
  logic [31:0]        sec_r;
  logic [14:0]        subs_r;
  logic [63:0]        ticks_r;
  logic               rst_req_r;

  // Working registers.
  logic [63:0]        dt_r;
  logic [D_W-1:0]     d_r;
  logic [NUM_W-1:0]   num_r;
  logic [DVS_W-1:0]   dvs_r;
  logic               neg_r;
  logic [DVS_W-1:0]   rem_r;
  logic [Q_W-1:0]     quo_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [9:0]  ppm_r;
  logic [31:0]        ref_ms_r;
  logic [31:0]        rtc_ms_r;
  logic [31:0]        mag_r;
  logic signed [15:0] drift_r;
  logic [1:0]         act_r;

  // Output register.
  logic               out_valid_r;
  logic [1:0]         out_action_r;
  logic signed [9:0]  out_cal_code_r;
  logic signed [9:0]  out_cal_ppm_r;
  logic [31:0]        out_ref_ms_r;
  logic [31:0]        out_rtc_ms_r;
  logic signed [15:0] out_drift_r;

  logic               in_acc;
  logic               done_load;
  logic               stamp_reset;
  logic [9:0]         code_mag;
  logic [23:0]        ppm_num;
  logic [HI_W-1:0]    div_hi;
  logic               div_ovf;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     trial_diff;
  logic               trial_ge;
  logic [31:0]        quo_sat;
  logic [NUM_W-1:0]   ref_num;
  logic [28:0]        hz_eff;
  logic [31:0]        ds;
  logic [D_W-1:0]     ds_sp;
  logic signed [S_W-1:0] d_s;
  logic [D_W-1:0]     d_clamp;
  logic [RN_W-1:0]    rtc_num;
  logic [32:0]        disp;
  logic [31:0]        disp_mag;
  logic [53:0]        dr_num;
  logic               dr_sat;
  logic signed [15:0] drift_nxt;
  logic signed [9:0]  ppm_nxt;
  logic signed [16:0] trim_diff;
  logic signed [15:0] trim_ppm;
  logic [15:0]        trim_mag;
  logic [30:0]        cd_num;
  logic signed [9:0]  code_nxt;

  // Handshake.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign done_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // No stamp saved yet, or an explicit request, restarts the measurement.
  assign stamp_reset = rst_req_r || (sv_sec_r == 32'd0);

  // Present trim ppm: rounded |code| * STEP_NUM / STEP_DEN, sign opposite to the code.
  assign code_mag = trim_code_r[9] ? (10'd0 - $unsigned(trim_code_r)) : $unsigned(trim_code_r);
  assign ppm_num  = 24'(code_mag) * 24'(2 * rdat_pkg::STEP_NUM) + 24'(rdat_pkg::STEP_DEN);
  assign ppm_nxt  = neg_r ? $signed(10'd0 - quo_r[9:0]) : $signed(quo_r[9:0]);

  // Divider load: the upper part becomes the first remainder; a quotient that
  // would not fit in 32 bits shows up as an upper part at or above the divisor.
  assign div_hi  = num_r[NUM_W-1:Q_W];
  assign div_ovf = (div_hi >= HI_W'(dvs_r));

  // One restoring division step.
  assign trial      = {rem_r, quo_r[Q_W-1]};
  assign trial_diff = trial - {1'b0, dvs_r};
  assign trial_ge   = (trial >= {1'b0, dvs_r});
  assign quo_sat    = ovf_r ? 32'hFFFF_FFFF : quo_r;

  // Reference milliseconds: ticks * 1000 / hz.
  assign hz_eff  = (hz_r == 29'd0) ? 29'd1 : hz_r;
  assign ref_num = NUM_W'(dt_r) * NUM_W'(rdat_pkg::MS_SCALE);

  // RTC elapsed subseconds, negative totals count as zero.
  assign ds      = sec_r - sv_sec_r;
  assign ds_sp   = D_W'(ds) * D_W'(SUBS_SPAN);
  assign d_s     = S_W'(ds_sp) + S_W'(subs_r) - S_W'(sv_subs_r);
  assign d_clamp = d_s[S_W-1] ? '0 : d_s[D_W-1:0];
  assign rtc_num = RN_W'(d_r) * RN_W'(rdat_pkg::MS_SCALE);

  // Displacement between the RTC and the reference clock and the rounded drift numerator.
  assign disp     = {1'b0, rtc_ms_r} - {1'b0, ref_ms_r};
  assign disp_mag = disp[32] ? (ref_ms_r - rtc_ms_r) : disp[31:0];
  assign dr_num   = 54'(mag_r) * 54'(2 * rdat_pkg::PPM_SCALE) + 54'(ref_ms_r);

  // Drift saturates to 16 bits; the negative side reaches one further.
  always_comb begin
    if (neg_r) begin
      dr_sat    = ovf_r || (quo_r > 32'd32768);
      drift_nxt = dr_sat ? rdat_pkg::DRIFT_MIN : $signed(16'd0 - quo_r[15:0]);
    end else begin
      dr_sat    = ovf_r || (quo_r > 32'd32767);
      drift_nxt = dr_sat ? rdat_pkg::DRIFT_MAX : $signed(quo_r[15:0]);
    end
  end

  // New trim in ppm, saturated to 16 bits, then split into magnitude and sign.
  always_comb begin
    trim_diff = 17'(ppm_r) - 17'(drift_r);
    if (!trim_diff[16] && trim_diff[15]) begin
      trim_ppm = rdat_pkg::DRIFT_MAX;
    end else if (trim_diff[16] && !trim_diff[15]) begin
      trim_ppm = rdat_pkg::DRIFT_MIN;
    end else begin
      trim_ppm = trim_diff[15:0];
    end
    trim_mag = trim_ppm[15] ? (16'd0 - $unsigned(trim_ppm)) : $unsigned(trim_ppm);
  end

  // Back to a code: rounded |ppm| * STEP_DEN / STEP_NUM, saturated to ten bits.
  assign cd_num = 31'(mag_r[15:0]) * 31'(2 * rdat_pkg::STEP_DEN) + 31'(rdat_pkg::STEP_NUM);

  always_comb begin
    if (neg_r) begin
      code_nxt = (quo_r > 32'd512) ? rdat_pkg::CODE_MIN : $signed(10'd0 - quo_r[9:0]);
    end else begin
      code_nxt = (quo_r > 32'd511) ? rdat_pkg::CODE_MAX : $signed(quo_r[9:0]);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOAD;
      end
      S_LOAD:     state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == CNT_W'(Q_W - 1)) state_nxt = ret_r;
      end
      S_PPM_END:  state_nxt = stamp_reset ? S_DONE : S_DT;
      S_DT:       state_nxt = S_REF_PREP;
      S_REF_PREP: state_nxt = S_LOAD;
      S_REF_END:  state_nxt = (quo_sat > min_ms_r) ? S_SUB : S_DONE;
      S_SUB:      state_nxt = S_RTC_PREP;
      S_RTC_PREP: state_nxt = S_LOAD;
      S_RTC_END:  state_nxt = S_DISP;
      S_DISP:     state_nxt = S_DR_PREP;
      S_DR_PREP:  state_nxt = S_LOAD;
      S_DR_END:   state_nxt = S_CODE;
      S_CODE:     state_nxt = S_CD_PREP;
      S_CD_PREP:  state_nxt = S_LOAD;
      S_CD_END:   state_nxt = S_DONE;
      S_DONE: begin
        if (done_load) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration, saved stamps and trim code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hz_r        <= rdat_pkg::REF_CLOCK_RESET;
      min_ms_r    <= rdat_pkg::MIN_INTERVAL_RESET;
      sv_sec_r    <= '0;
      sv_subs_r   <= '0;
      sv_ticks_r  <= '0;
      trim_code_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          rdat_pkg::CFG_REF_CLOCK:    hz_r     <= cfg_data[28:0];
          rdat_pkg::CFG_MIN_INTERVAL: min_ms_r <= cfg_data;
          default: ;
        endcase
      end

      // Stamps are saved on a restart and after every trim update.
      if (((state_r == S_PPM_END) && stamp_reset) || (state_r == S_CD_END)) begin
        sv_sec_r   <= sec_r;
        sv_subs_r  <= subs_r;
        sv_ticks_r <= ticks_r;
      end
      if (state_r == S_CD_END) begin
        trim_code_r <= code_nxt;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sec_r     <= in_rtc_seconds;
          subs_r    <= in_rtc_subs;
          ticks_r   <= in_ref_ticks;
          rst_req_r <= in_reset_request;
          act_r     <= rdat_pkg::ACT_WAIT;
          ref_ms_r  <= '0;
          rtc_ms_r  <= '0;
          drift_r   <= '0;
          num_r     <= NUM_W'(ppm_num);
          dvs_r     <= DVS_W'(2 * rdat_pkg::STEP_DEN);
          neg_r     <= !trim_code_r[9] && (trim_code_r != 10'sd0);
          ret_r     <= S_PPM_END;
        end
      end
      S_LOAD: begin
        rem_r <= div_hi[DVS_W-1:0];
        quo_r <= num_r[Q_W-1:0];
        ovf_r <= div_ovf;
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_r <= {quo_r[Q_W-2:0], trial_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      S_PPM_END: begin
        ppm_r <= ppm_nxt;
        if (stamp_reset) act_r <= rdat_pkg::ACT_RESET;
      end
      S_DT: begin
        dt_r <= ticks_r - sv_ticks_r;
      end
      S_REF_PREP: begin
        num_r <= ref_num;
        dvs_r <= DVS_W'(hz_eff);
        ret_r <= S_REF_END;
      end
      S_REF_END: begin
        ref_ms_r <= quo_sat;
      end
      S_SUB: begin
        d_r <= d_clamp;
      end
      S_RTC_PREP: begin
        num_r <= NUM_W'(rtc_num);
        dvs_r <= DVS_W'(SUBS_SPAN);
        ret_r <= S_RTC_END;
      end
      S_RTC_END: begin
        rtc_ms_r <= quo_sat;
      end
      S_DISP: begin
        mag_r <= disp_mag;
        neg_r <= disp[32];
      end
      S_DR_PREP: begin
        num_r <= NUM_W'(dr_num);
        dvs_r <= {ref_ms_r, 1'b0};
        ret_r <= S_DR_END;
      end
      S_DR_END: begin
        drift_r <= drift_nxt;
      end
      S_CODE: begin
        mag_r <= 32'(trim_mag);
        neg_r <= !trim_ppm[15] && (trim_ppm != 16'sd0);
      end
      S_CD_PREP: begin
        num_r <= NUM_W'(cd_num);
        dvs_r <= DVS_W'(2 * rdat_pkg::STEP_NUM);
        ret_r <= S_CD_END;
      end
      S_CD_END: begin
        act_r <= rdat_pkg::ACT_TRIM;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (done_load) begin
      out_action_r   <= act_r;
      out_cal_code_r <= trim_code_r;
      out_cal_ppm_r  <= ppm_r;
      out_ref_ms_r   <= ref_ms_r;
      out_rtc_ms_r   <= rtc_ms_r;
      out_drift_r    <= drift_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_cal_code       = out_cal_code_r;
  assign out_cal_ppm        = out_cal_ppm_r;
  assign out_ref_elapsed_ms = out_ref_ms_r;
  assign out_rtc_elapsed_ms = out_rtc_ms_r;
  assign out_drift_ppm      = out_drift_r;

endmodule
